// File: rtl/bitmap_block_allocator_macros.svh
// Assertion macros for the bitmap block allocator checker.
// All macros need i_clk, and all but BBA_ASSERT_RST i_rst_n, in scope.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define BBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bitmap block allocator check failed");

// Next-cycle implication, masked while reset is asserted
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap block allocator check failed");

// Next-cycle implication that also holds through reset
`define BBA_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bitmap block allocator reset check failed");

`endif

// File: rtl/bba_pkg.sv
// Shared constants, codes and types of the bitmap block allocator.
// No dependencies; each other .sv file uses its scoped names.
package bba_pkg;

    localparam int NUM_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = $clog2(WORD_COUNT);
    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

    // Response status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(4096);

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [ADDR_W-1:0]    t_waddr;
    typedef logic [ADDR_W:0]      t_wcount;
    typedef logic [BIT_W-1:0]     t_bitpos;
    typedef logic [CNT_W-1:0]     t_count;
    typedef logic [IDX_W-1:0]     t_index;

    // First-free search result
    typedef struct packed {
        logic    found;
        t_bitpos pos;
    } t_ffz_res;

endpackage

// File: rtl/bba_req_if.sv
// Request channel of the bitmap block allocator.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
    logic                            valid;
    logic                            ready;
    logic [bba_pkg::KIND_W-1:0]      kind;
    logic [bba_pkg::IDX_W-1:0]       block_index;

    modport source (output valid, output kind, output block_index, input ready);
    modport sink   (input valid, input kind, input block_index, output ready);
endinterface

// File: rtl/bba_rsp_if.sv
// Response channel of the bitmap block allocator.
// Depends on bba_pkg for the field widths.
interface bba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bba_pkg::STAT_W-1:0]      status;
    logic [bba_pkg::IDX_W-1:0]       result_index;
    logic                            bit_set;
    logic [bba_pkg::CNT_W-1:0]       free_count;

    modport source (output valid, output status, output result_index, output bit_set,
                    output free_count, input ready);
    modport sink   (input valid, input status, input result_index, input bit_set,
                    input free_count, output ready);
endinterface

// File: rtl/bba_cfg_if.sv
// Configuration write channel carrying the block_count register.
// Depends on bba_pkg for the register width.
interface bba_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bba_pkg::CNT_W-1:0]       block_count;

    modport source (output valid, output block_count, input ready);
    modport sink   (input valid, input block_count, output ready);
endinterface

// File: rtl/bitmap_block_allocator.sv
// Bitmap first-fit block allocator. One request at a time; ready only when idle.
// Allocate scans the bitmap words in order, one word per cycle through the RAM read
// port, until the word holding a free block or the last of up to 128 words;
// free and check do one RAM read; rejected requests go straight to the response.
// Reset clears the per-row valid flags at once (no clearing pass), the used count
// and the response; block_count returns to 4096.
module bitmap_block_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bba_req_if.sink       i_req,
    bba_rsp_if.source     o_rsp,
    bba_cfg_if.sink       i_cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RDW   = 3'd2;
    localparam logic [2:0] S_BITOP = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [bba_pkg::KIND_W-1:0]   r_kind;
    bba_pkg::t_index              r_idx;
    bba_pkg::t_wcount             r_addr;
    bba_pkg::t_waddr              r_chk;
    logic                         r_dv;
    bba_pkg::t_count              r_used;
    bba_pkg::t_count              r_cnt;
    logic [bba_pkg::STAT_W-1:0]   r_status;
    bba_pkg::t_index              r_res_idx;
    logic                         r_bit;

    bba_pkg::t_word               r_mem [bba_pkg::WORD_COUNT];
    bba_pkg::t_word               r_mem_q;
    logic                         r_q_vld;
    logic [bba_pkg::WORD_COUNT-1:0] r_row_vld;

    logic                         r_o_valid;
    logic [bba_pkg::STAT_W-1:0]   r_o_status;
    bba_pkg::t_index              r_o_idx;
    logic                         r_o_bit;
    bba_pkg::t_count              r_o_free;

    bba_pkg::t_count              w_eff_n;
    bba_pkg::t_count              w_round;
    bba_pkg::t_wcount             w_words_n;
    bba_pkg::t_wcount             w_full_words;
    bba_pkg::t_word               w_word;
    bba_pkg::t_ffz_res            w_ffz;
    logic                         w_chk_full;
    logic                         w_last;
    logic                         w_accept;
    logic                         w_out_load;
    logic                         w_bit;
    logic                         w_rd_en;
    bba_pkg::t_waddr              w_rd_addr;
    logic                         w_wr_en;
    bba_pkg::t_waddr              w_wr_addr;
    bba_pkg::t_word               w_wr_data;
    bba_pkg::t_word               w_bit_mask;

    // Handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_load  = (r_state == S_FIN) && (!r_o_valid || o_rsp.ready);

    // Effective block count and word limits
    assign w_eff_n      = (r_cnt > bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS))
                          ? bba_pkg::CNT_W'(bba_pkg::NUM_BLOCKS) : r_cnt;
    assign w_round      = w_eff_n + bba_pkg::CNT_W'(bba_pkg::WORD_BITS - 1);
    assign w_words_n    = w_round[bba_pkg::CNT_W-1:bba_pkg::BIT_W];
    assign w_full_words = w_eff_n[bba_pkg::CNT_W-1:bba_pkg::BIT_W];

    // Bitmap word as returned by the RAM; rows never written read as all free
    assign w_word     = r_q_vld ? r_mem_q : '0;
    assign w_chk_full = {1'b0, r_chk} < w_full_words;
    assign w_last     = ({1'b0, r_chk} == (w_words_n - 1'b1));
    assign w_bit      = w_word[r_idx[bba_pkg::BIT_W-1:0]];
    assign w_bit_mask = bba_pkg::WORD_BITS'(1) << r_idx[bba_pkg::BIT_W-1:0];

    bba_ffz u_ffz (
        .i_word (w_word),
        .i_full (w_chk_full),
        .i_lim  (w_eff_n[bba_pkg::BIT_W-1:0]),
        .o_res  (w_ffz)
    );

    // RAM port control
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_addr[bba_pkg::ADDR_W-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_chk;
        w_wr_data = w_word | (bba_pkg::WORD_BITS'(1) << w_ffz.pos);
        unique case (r_state)
            S_SCAN: begin
                w_rd_en = !(r_dv && w_ffz.found) && (r_addr < w_words_n);
                w_wr_en = r_dv && w_ffz.found;
            end
            S_RDW: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_idx[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
            end
            S_BITOP: begin
                w_wr_en   = (r_kind == bba_pkg::KIND_FREE) && w_bit;
                w_wr_addr = r_idx[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
                w_wr_data = w_word & ~w_bit_mask;
            end
            default: begin
            end
        endcase
    end

    // Bitmap RAM: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[w_rd_addr];
            r_q_vld <= r_row_vld[w_rd_addr];
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.kind) inside
                        bba_pkg::KIND_ALLOC:
                            n_state = (w_eff_n == '0) ? S_FIN : S_SCAN;
                        bba_pkg::KIND_FREE, bba_pkg::KIND_CHECK:
                            n_state = ({1'b0, i_req.block_index} >= w_eff_n) ? S_FIN : S_RDW;
                        default:
                            n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN:  n_state = (r_dv && (w_ffz.found || w_last)) ? S_FIN : S_SCAN;
            S_RDW:   n_state = S_BITOP;
            S_BITOP: n_state = S_FIN;
            S_FIN:   n_state = w_out_load ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_cnt     <= bba_pkg::COUNT_RESET;
            r_row_vld <= '0;
            r_o_valid <= 1'b0;
            r_dv      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cnt <= i_cfg.block_count;
            end
            if (w_wr_en) begin
                r_row_vld[w_wr_addr] <= 1'b1;
            end
            // Count only real bit changes
            if (r_state == S_SCAN && r_dv && w_ffz.found) begin
                r_used <= r_used + 1'b1;
            end else if (r_state == S_BITOP && w_wr_en && r_used != '0) begin
                r_used <= r_used - 1'b1;
            end
            // Track which RAM word the read data belongs to
            if (r_state == S_SCAN) begin
                r_dv <= w_rd_en;
            end else begin
                r_dv <= 1'b0;
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request payload and result registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= i_req.kind;
            r_idx     <= i_req.block_index;
            r_res_idx <= i_req.block_index;
            r_bit     <= 1'b0;
            r_addr    <= '0;
            r_status  <= bba_pkg::STAT_OK;
            unique case (i_req.kind) inside
                bba_pkg::KIND_ALLOC: begin
                    if (w_eff_n == '0) begin
                        r_status  <= bba_pkg::STAT_NOFREE;
                        r_res_idx <= '0;
                    end
                end
                bba_pkg::KIND_FREE, bba_pkg::KIND_CHECK: begin
                    if ({1'b0, i_req.block_index} >= w_eff_n) begin
                        r_status <= bba_pkg::STAT_RANGE;
                    end
                end
                default: begin
                    r_status <= bba_pkg::STAT_RANGE;
                end
            endcase
        end
        // Advance the scan address and take the scan verdict
        if (r_state == S_SCAN) begin
            if (w_rd_en) begin
                r_addr <= r_addr + 1'b1;
                r_chk  <= r_addr[bba_pkg::ADDR_W-1:0];
            end
            if (r_dv && w_ffz.found) begin
                r_res_idx <= {r_chk, w_ffz.pos};
            end else if (r_dv && w_last) begin
                r_status  <= bba_pkg::STAT_NOFREE;
                r_res_idx <= '0;
            end
        end
        if (r_state == S_BITOP && r_kind == bba_pkg::KIND_CHECK) begin
            r_bit <= w_bit;
        end
        // Load the response holding register
        if (w_out_load) begin
            r_o_status <= r_status;
            r_o_idx    <= r_res_idx;
            r_o_bit    <= r_bit;
            r_o_free   <= (w_eff_n > r_used) ? (w_eff_n - r_used) : '0;
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.result_index = r_o_idx;
    assign o_rsp.bit_set      = r_o_bit;
    assign o_rsp.free_count   = r_o_free;

endmodule

// File: rtl/bba_ffz.sv
// Find-first-free unit: lowest clear bit of one bitmap word within the block limit.
// Depends on bba_pkg.
module bba_ffz (
    input  bba_pkg::t_word    i_word,
    input  logic              i_full,
    input  bba_pkg::t_bitpos  i_lim,
    output bba_pkg::t_ffz_res o_res
);

    bba_pkg::t_word w_avail;

    // Mark bits that are free and lie below the block count
    always_comb begin
        for (int j = 0; j < bba_pkg::WORD_BITS; j++) begin
            w_avail[j] = !i_word[j] && (i_full || (bba_pkg::BIT_W'(j) < i_lim));
        end
    end

    // Priority-encode the lowest available bit
    always_comb begin
        o_res.found = |w_avail;
        o_res.pos   = '0;
        for (int j = bba_pkg::WORD_BITS - 1; j >= 0; j--) begin
            if (w_avail[j]) begin
                o_res.pos = bba_pkg::BIT_W'(j);
            end
        end
    end

endmodule

// File: rtl/bba_chk.sv
// Port-level checker of the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_macros.svh.
`include "bitmap_block_allocator_macros.svh"

module bba_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [bba_pkg::STAT_W-1:0]   i_rsp_status,
    input logic [bba_pkg::IDX_W-1:0]    i_rsp_index,
    input logic                         i_rsp_bit,
    input logic [bba_pkg::CNT_W-1:0]    i_rsp_free
);

    // Reset drops a pending response
    `BBA_ASSERT_RST(a_rst_clears, !i_rst_n, !i_rsp_valid)

    // One request in flight: ready falls after each accepted transaction
    `BBA_ASSERT_NEXT(a_busy_after_accept, i_req_valid && i_req_ready, !i_req_ready)

    // A stalled response holds
    `BBA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_index)
        && $stable(i_rsp_bit) && $stable(i_rsp_free))

    // A full bitmap reports index zero and nothing left
    `BBA_ASSERT_NOW(a_nofree_empty, i_rsp_valid && i_rsp_status == bba_pkg::STAT_NOFREE,
        i_rsp_index == '0 && i_rsp_free == '0)

    // The used flag is only reported on a successful transaction
    `BBA_ASSERT_NOW(a_bit_ok_only, i_rsp_valid && i_rsp_bit,
        i_rsp_status == bba_pkg::STAT_OK)

endmodule

bind bitmap_block_allocator bba_chk u_bba_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_index  (o_rsp.result_index),
    .i_rsp_bit    (o_rsp.bit_set),
    .i_rsp_free   (o_rsp.free_count)
);

// File: sim/tb_bitmap_block_allocator.sv
// Self-checking testbench for the bitmap first-fit block allocator.
// Needs bba_pkg and the bba_req_if, bba_rsp_if and bba_cfg_if interfaces from the RTL;
// a shadow bitmap predicts every reply under random idling on request and reply side.
module tb_bitmap_block_allocator;

    // Kind code that the block must reject
    localparam logic [bba_pkg::KIND_W-1:0] KIND_BAD = 2'd3;

    localparam int LONG_HOLD      = 300;   // receiver hold-off, long enough to stall requests
    localparam int SETTLE_CYCLES  = 140;   // beyond the slowest allocate
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is abandoned

    typedef struct packed {
        logic [bba_pkg::STAT_W-1:0] status;
        bba_pkg::t_index            result_index;
        logic                       bit_set;
        bba_pkg::t_count            free_count;
    } t_reply;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op                    op;
        bba_pkg::t_count            cfg_value;
        logic [bba_pkg::KIND_W-1:0] kind;
        bba_pkg::t_index            idx;
        logic                       typed;
        t_reply                     golden;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();
    bba_cfg_if cfg_if ();

    bitmap_block_allocator u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    always #2 clk = ~clk;

    // Shadow copy of the allocator state
    bba_pkg::t_word  shadow_map [bba_pkg::WORD_COUNT];
    int              shadow_used  = 0;
    bba_pkg::t_count shadow_count = bba_pkg::COUNT_RESET;

    t_reply   pending_replies [$];
    t_dir_row dir_rows [$];

    int   mismatches  = 0;
    int   quiet_cycles = 0;
    bit   tx_hi       = 1'b0;
    bit   tx_idle     = 1'b1;
    bit   rx_idle     = 1'b1;
    bit   rx_hold_req = 1'b0;
    int   rx_gap      = 0;
    int   rx_cycles   = 0;
    t_reply rx_want;

    function automatic int eff_count();
        return (shadow_count > bba_pkg::NUM_BLOCKS) ? bba_pkg::NUM_BLOCKS : int'(shadow_count);
    endfunction

    // Compute the reply to one request and advance the shadow state
    function automatic t_reply predict_reply(logic [bba_pkg::KIND_W-1:0] kind,
                                             bba_pkg::t_index idx);
        t_reply r;
        int     eff;
        int     blk;
        bit     found;
        r.status       = bba_pkg::STAT_OK;
        r.result_index = idx;
        r.bit_set      = 1'b0;
        eff            = eff_count();
        case (kind)
            bba_pkg::KIND_ALLOC: begin
                found = 1'b0;
                blk   = 0;
                for (int w = 0; w < bba_pkg::WORD_COUNT && !found
                     && w * bba_pkg::WORD_BITS < eff; w++) begin
                    if (shadow_map[w] != '1) begin
                        for (int b = 0; b < bba_pkg::WORD_BITS && !found; b++) begin
                            if (!shadow_map[w][b] && (w * bba_pkg::WORD_BITS + b) < eff) begin
                                found = 1'b1;
                                blk   = w * bba_pkg::WORD_BITS + b;
                            end
                        end
                    end
                end
                if (found) begin
                    shadow_map[blk / bba_pkg::WORD_BITS][blk % bba_pkg::WORD_BITS] = 1'b1;
                    shadow_used++;
                    r.result_index = bba_pkg::t_index'(blk);
                end else begin
                    r.status       = bba_pkg::STAT_NOFREE;
                    r.result_index = '0;
                end
            end
            bba_pkg::KIND_FREE: begin
                if (idx >= eff) begin
                    r.status = bba_pkg::STAT_RANGE;
                end else if (shadow_map[idx / bba_pkg::WORD_BITS][idx % bba_pkg::WORD_BITS]) begin
                    shadow_map[idx / bba_pkg::WORD_BITS][idx % bba_pkg::WORD_BITS] = 1'b0;
                    if (shadow_used > 0)
                        shadow_used--;
                end
            end
            bba_pkg::KIND_CHECK: begin
                if (idx >= eff)
                    r.status = bba_pkg::STAT_RANGE;
                else
                    r.bit_set = shadow_map[idx / bba_pkg::WORD_BITS][idx % bba_pkg::WORD_BITS];
            end
            default: r.status = bba_pkg::STAT_RANGE;
        endcase
        r.free_count = (eff > shadow_used) ? bba_pkg::t_count'(eff - shadow_used) : '0;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bba_pkg::t_index pick_index();
        int hi;
        int r;
        hi = eff_count() + 2;
        if (hi > 4095)
            hi = 4095;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return '1;
            2:       return bba_pkg::t_index'($urandom);
            default: return bba_pkg::t_index'($urandom_range(0, hi));
        endcase
    endfunction

    function automatic logic [bba_pkg::KIND_W-1:0] pick_kind(int pa, int pf, int pc);
        int r;
        r = $urandom_range(0, 99);
        if (r < pa)
            return bba_pkg::KIND_ALLOC;
        else if (r < pa + pf)
            return bba_pkg::KIND_FREE;
        else if (r < pa + pf + pc)
            return bba_pkg::KIND_CHECK;
        return KIND_BAD;
    endfunction

    function automatic void dir_req(logic [bba_pkg::KIND_W-1:0] kind, bba_pkg::t_index idx,
                                    logic typed, logic [bba_pkg::STAT_W-1:0] st,
                                    bba_pkg::t_index ri, logic bs, bba_pkg::t_count fc);
        t_dir_row row;
        row      = '{ROW_REQ, bba_pkg::t_count'(0), kind, idx, typed, '{st, ri, bs, fc}};
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void dir_cfg(bba_pkg::t_count value);
        t_dir_row row;
        row      = '{ROW_CFG, value, bba_pkg::KIND_ALLOC, bba_pkg::t_index'(0), 1'b0,
                     t_reply'(0)};
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // Offer one request, hold it until accepted, then queue its predicted reply
    task automatic issue_request(logic [bba_pkg::KIND_W-1:0] kind, bba_pkg::t_index idx,
                                 logic typed, t_reply golden);
        t_reply got;
        int     gap;
        req_if.kind        <= kind;
        req_if.block_index <= idx;
        if (!tx_hi) begin
            req_if.valid <= 1'b1;
            tx_hi = 1'b1;
        end
        do @(posedge clk); while (req_if.ready !== 1'b1);
        got = predict_reply(kind, idx);
        if (typed)
            got = golden;
        pending_replies = {pending_replies, got};
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            tx_hi = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop the request and wait until every reply is back
    task automatic drain_replies();
        if (tx_hi) begin
            req_if.valid <= 1'b0;
            tx_hi = 1'b0;
        end
        while (pending_replies.size() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_count(bba_pkg::t_count value);
        drain_replies();
        cfg_if.valid       <= 1'b1;
        cfg_if.block_count <= value;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        shadow_count = value;
    endtask

    task automatic run_phase(bba_pkg::t_count count, int items, int pa, int pf, int pc,
                             bit long_hold);
        write_count(count);
        if (long_hold) begin
            @(negedge clk);
            rx_hold_req = 1'b1;
            @(posedge clk);
        end
        for (int n = 0; n < items; n++) begin
            if (n % 40 == 0)
                tx_idle = ($urandom_range(0, 3) != 0);
            issue_request(pick_kind(pa, pf, pc), pick_index(), 1'b0, t_reply'(0));
        end
    endtask

    // Receiver: check each reply against the oldest expectation, idle at random
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none actual status %0d index %0d",
                             $time, rsp_if.status, rsp_if.result_index);
                    mismatches++;
                end else begin
                    rx_want = pending_replies.pop_front();
                    compare_field("status", 16'(rx_want.status), 16'(rsp_if.status));
                    compare_field("result_index", 16'(rx_want.result_index),
                                  16'(rsp_if.result_index));
                    compare_field("bit_set", 16'(rx_want.bit_set), 16'(rsp_if.bit_set));
                    compare_field("free_count", 16'(rx_want.free_count),
                                  16'(rsp_if.free_count));
                end
            end
            rx_cycles++;
            if (rx_cycles % 128 == 0)
                rx_idle = ($urandom_range(0, 3) != 0);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_gap = LONG_HOLD;
            end
            if (rx_gap > 0) begin
                rsp_if.ready <= 1'b0;
                rx_gap--;
            end else begin
                rsp_if.ready <= 1'b1;
                rx_gap = rx_idle ? pick_gap() : 0;
            end
        end
    end

    // Abandon the run when no transaction moves for too long
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmap_block_allocator regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row row;
        req_if.valid       <= 1'b0;
        req_if.kind        <= bba_pkg::KIND_ALLOC;
        req_if.block_index <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.block_count <= bba_pkg::COUNT_RESET;
        rst_n              <= 1'b0;
        foreach (shadow_map[w])
            shadow_map[w] = '0;

        // Directed rows: fresh map, free of a free block, bad kind, zero/one/oversized counts
        dir_req(bba_pkg::KIND_ALLOC, 12'd0,    1, bba_pkg::STAT_OK,     12'd0,    0, 13'd4095);
        dir_req(bba_pkg::KIND_ALLOC, 12'd4095, 1, bba_pkg::STAT_OK,     12'd1,    0, 13'd4094);
        dir_req(bba_pkg::KIND_CHECK, 12'd0,    1, bba_pkg::STAT_OK,     12'd0,    1, 13'd4094);
        dir_req(bba_pkg::KIND_CHECK, 12'd4095, 1, bba_pkg::STAT_OK,     12'd4095, 0, 13'd4094);
        dir_req(bba_pkg::KIND_FREE,  12'd4095, 1, bba_pkg::STAT_OK,     12'd4095, 0, 13'd4094);
        dir_req(bba_pkg::KIND_FREE,  12'd0,    1, bba_pkg::STAT_OK,     12'd0,    0, 13'd4095);
        dir_req(bba_pkg::KIND_ALLOC, 12'd0,    1, bba_pkg::STAT_OK,     12'd0,    0, 13'd4094);
        dir_req(KIND_BAD,            12'd4095, 1, bba_pkg::STAT_RANGE,  12'd4095, 0, 13'd4094);
        dir_req(KIND_BAD,            12'd0,    1, bba_pkg::STAT_RANGE,  12'd0,    0, 13'd4094);
        dir_cfg(13'd0);
        dir_req(bba_pkg::KIND_ALLOC, 12'd0,    1, bba_pkg::STAT_NOFREE, 12'd0,    0, 13'd0);
        dir_req(bba_pkg::KIND_FREE,  12'd0,    1, bba_pkg::STAT_RANGE,  12'd0,    0, 13'd0);
        dir_req(bba_pkg::KIND_CHECK, 12'd4095, 1, bba_pkg::STAT_RANGE,  12'd4095, 0, 13'd0);
        dir_cfg(13'd1);
        dir_req(bba_pkg::KIND_CHECK, 12'd0,    1, bba_pkg::STAT_OK,     12'd0,    1, 13'd0);
        dir_req(bba_pkg::KIND_ALLOC, 12'd0,    1, bba_pkg::STAT_NOFREE, 12'd0,    0, 13'd0);
        dir_req(bba_pkg::KIND_FREE,  12'd1,    1, bba_pkg::STAT_RANGE,  12'd1,    0, 13'd0);
        dir_req(bba_pkg::KIND_FREE,  12'd0,    1, bba_pkg::STAT_OK,     12'd0,    0, 13'd0);
        dir_req(bba_pkg::KIND_ALLOC, 12'd0,    1, bba_pkg::STAT_OK,     12'd0,    0, 13'd0);
        dir_cfg(13'd8191);
        dir_req(bba_pkg::KIND_CHECK, 12'd4095, 1, bba_pkg::STAT_OK,     12'd4095, 0, 13'd4094);
        dir_req(bba_pkg::KIND_FREE,  12'd1,    1, bba_pkg::STAT_OK,     12'd1,    0, 13'd4095);
        dir_req(bba_pkg::KIND_ALLOC, 12'd0,    1, bba_pkg::STAT_OK,     12'd1,    0, 13'd4094);
        dir_req(bba_pkg::KIND_CHECK, 12'd2048, 0, bba_pkg::STAT_OK,     12'd0,    0, 13'd0);
        dir_cfg(13'd4096);
        dir_req(bba_pkg::KIND_ALLOC, 12'd0,    0, bba_pkg::STAT_OK,     12'd0,    0, 13'd0);
        dir_req(bba_pkg::KIND_FREE,  12'd2,    0, bba_pkg::STAT_OK,     12'd0,    0, 13'd0);
        dir_req(bba_pkg::KIND_CHECK, 12'hAAA,  0, bba_pkg::STAT_OK,     12'd0,    0, 13'd0);
        dir_req(bba_pkg::KIND_CHECK, 12'h555,  0, bba_pkg::STAT_OK,     12'd0,    0, 13'd0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.op == ROW_CFG)
                write_count(row.cfg_value);
            else
                issue_request(row.kind, row.idx, row.typed, row.golden);
        end

        // Fill the low blocks, then mix requests under assorted counts
        run_phase(13'd4096, 120, 96, 0, 3, 1'b1);
        run_phase(13'd4096, 100, 35, 35, 22, 1'b0);
        run_phase(bba_pkg::t_count'($urandom_range(1, 40)), 80, 35, 40, 20, 1'b1);
        run_phase(13'd0, 20, 40, 25, 25, 1'b0);
        run_phase(bba_pkg::t_count'($urandom_range(4097, 8191)), 50, 35, 35, 25, 1'b0);
        run_phase(13'd8191, 20, 35, 35, 25, 1'b0);
        run_phase(bba_pkg::t_count'($urandom_range(1, 4096)), 70, 40, 35, 20, 1'b0);
        run_phase(13'd1, 30, 40, 30, 25, 1'b0);
        run_phase(13'd4096, 40, 40, 35, 20, 1'b0);

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("bitmap_block_allocator regression: pass");
        else
            $display("bitmap_block_allocator regression: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_req_if.sv
rtl/bba_rsp_if.sv
rtl/bba_cfg_if.sv
rtl/bba_ffz.sv
rtl/bitmap_block_allocator.sv
rtl/bba_chk.sv
sim/tb_bitmap_block_allocator.sv
